[hdl/cte_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none

package cte_pkg;

  // field widths
  localparam int unsigned ChW     = 8;
  localparam int unsigned PosW    = 5;
  localparam int unsigned YearW   = 14;
  localparam int unsigned FieldW  = 7;
  localparam int unsigned EpochW  = 32;
  localparam int unsigned YoeW    = 7;
  localparam int unsigned MpW     = 4;
  localparam int unsigned DoyW    = 9;
  localparam int unsigned HmsW    = 17;
  localparam int unsigned DaysW   = 16;
  localparam int unsigned SecsW   = EpochW + 1;

  // string layout
  localparam logic [PosW-1:0] PosMonth  = PosW'(4);
  localparam logic [PosW-1:0] PosDay    = PosW'(6);
  localparam logic [PosW-1:0] PosSep    = PosW'(8);
  localparam logic [PosW-1:0] PosMinute = PosW'(11);
  localparam logic [PosW-1:0] PosSecond = PosW'(13);
  localparam logic [PosW-1:0] PosLen    = PosW'(15);
  localparam logic [PosW-1:0] PosSat    = PosW'(16);

  // characters
  localparam logic [ChW-1:0] CharSep  = 8'h54;
  localparam logic [ChW-1:0] CharZero = 8'h30;
  localparam logic [ChW-1:0] CharNine = 8'h39;

  // accepted ranges
  localparam logic [YearW-1:0]  YearMin   = YearW'(2024);
  localparam logic [YearW-1:0]  YearMax   = YearW'(2099);
  localparam logic [FieldW-1:0] MonthMax  = FieldW'(12);
  localparam logic [FieldW-1:0] DayMax    = FieldW'(31);
  localparam logic [FieldW-1:0] HourMax   = FieldW'(23);
  localparam logic [FieldW-1:0] MinSecMax = FieldW'(59);
  localparam logic [SecsW-1:0]  EpochMin  = SecsW'(1700000000);

  // days-from-civil, specialised to the era starting in 2000
  localparam int unsigned EraDays   = 146097;
  localparam int unsigned EraIndex  = 5;
  localparam int unsigned EpochDays = 719468;
  localparam logic [YearW-1:0] EraYear  = YearW'(EraIndex * 400);
  localparam logic [DaysW-1:0] DaysBase = DaysW'(EraIndex * EraDays - EpochDays);
  localparam logic [DaysW-1:0] DaysPerYear = DaysW'(365);
  localparam logic [SecsW-1:0] SecsPerDay  = SecsW'(86400);
  localparam logic [HmsW-1:0]  SecsPerHour = HmsW'(3600);
  localparam logic [HmsW-1:0]  SecsPerMin  = HmsW'(60);

  // day of year at the start of each month, counted from march
  function automatic logic [DoyW-1:0] month_start(input logic [MpW-1:0] mp);
    logic [DoyW-1:0] r;
    case (mp)
      4'd0:    r = DoyW'(0);
      4'd1:    r = DoyW'(31);
      4'd2:    r = DoyW'(61);
      4'd3:    r = DoyW'(92);
      4'd4:    r = DoyW'(122);
      4'd5:    r = DoyW'(153);
      4'd6:    r = DoyW'(184);
      4'd7:    r = DoyW'(214);
      4'd8:    r = DoyW'(245);
      4'd9:    r = DoyW'(275);
      4'd10:   r = DoyW'(306);
      4'd11:   r = DoyW'(337);
      default: r = DoyW'(0);
    endcase
    return r;
  endfunction

  // controller to datapath
  typedef struct packed {
    logic take;
    logic stage1;
    logic stage2;
    logic stage3;
    logic load;
  } cte_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic last_taken;
    logic out_free;
  } cte_stat_t;

endpackage

`default_nettype wire

[hdl/cte_ifs.sv]
`timescale 1ns / 1ps
`default_nettype none

interface cte_char_if
  import cte_pkg::*;
();
  logic           valid;
  logic           ready;
  logic [ChW-1:0] ch;
  logic           last;

  modport source (output valid, output ch, output last, input ready);
  modport sink   (input valid, input ch, input last, output ready);
endinterface

interface cte_result_if
  import cte_pkg::*;
();
  logic              valid;
  logic              ready;
  logic              valid_res;
  logic [EpochW-1:0] epoch;

  modport source (output valid, output valid_res, output epoch, input ready);
  modport sink   (input valid, input valid_res, input epoch, output ready);
endinterface

`default_nettype wire

[hdl/compact_timestamp_to_epoch.sv]
// sequencing: after the final character's transaction the controller steps through CALC1,
// CALC2, CALC3 and LOAD, its three calculation steps and the output load; the load waits
// while the output register still holds an unaccepted result, and the new result is then
// presented from that register; characters are taken one per cycle, but only in the scan state
// reset: synchronous active-high rst clears position, error flag, digit values and output valid
`timescale 1ns / 1ps
`default_nettype none

module compact_timestamp_to_epoch
  import cte_pkg::*;
(
  input wire logic     clk,
  input wire logic     rst,
  cte_char_if.sink     chars,
  cte_result_if.source result
);

  cte_cmd_t  cmd;
  cte_stat_t stat;

  assign chars.ready = cmd.take;

  // sequencing
  cte_ctrl u_ctrl (
    .clk  (clk),
    .rst  (rst),
    .stat (stat),
    .cmd  (cmd)
  );

  // parsing and date arithmetic
  cte_datapath u_datapath (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .stat          (stat),
    .in_valid      (chars.valid),
    .in_ch         (chars.ch),
    .in_last       (chars.last),
    .out_valid     (result.valid),
    .out_ready     (result.ready),
    .out_valid_res (result.valid_res),
    .out_epoch     (result.epoch)
  );

endmodule

`default_nettype wire

[hdl/cte_ctrl.sv]
`timescale 1ns / 1ps
`default_nettype none

module cte_ctrl
  import cte_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst,
  input  wire cte_stat_t stat,
  output cte_cmd_t       cmd
);

  typedef enum logic [4:0] {
    ST_SCAN  = 5'b00001,
    ST_CALC1 = 5'b00010,
    ST_CALC2 = 5'b00100,
    ST_CALC3 = 5'b01000,
    ST_LOAD  = 5'b10000
  } state_t;

  state_t state;
  state_t state_next;

  // next state
  always_comb begin
    state_next = state;
    case (state)
      ST_SCAN:  if (stat.last_taken) state_next = ST_CALC1;
      ST_CALC1: state_next = ST_CALC2;
      ST_CALC2: state_next = ST_CALC3;
      ST_CALC3: state_next = ST_LOAD;
      ST_LOAD:  if (stat.out_free) state_next = ST_SCAN;
      default:  state_next = ST_SCAN;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_SCAN;
    end else begin
      state <= state_next;
    end
  end

  // commands
  always_comb begin
    cmd.take   = (state == ST_SCAN);
    cmd.stage1 = (state == ST_CALC1);
    cmd.stage2 = (state == ST_CALC2);
    cmd.stage3 = (state == ST_CALC3);
    cmd.load   = (state == ST_LOAD) && stat.out_free;
  end

endmodule

`default_nettype wire

[hdl/cte_datapath.sv]
`timescale 1ns / 1ps
`default_nettype none

module cte_datapath
  import cte_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire cte_cmd_t          cmd,
  output cte_stat_t              stat,
  input  wire logic              in_valid,
  input  wire logic [ChW-1:0]    in_ch,
  input  wire logic              in_last,
  output logic                   out_valid,
  input  wire logic              out_ready,
  output logic                   out_valid_res,
  output logic [EpochW-1:0]      out_epoch
);

  // gathered state
  logic [PosW-1:0]   char_position;
  logic              format_error;
  logic [YearW-1:0]  year_value;
  logic [FieldW-1:0] month_value;
  logic [FieldW-1:0] day_value;
  logic [FieldW-1:0] hour_value;
  logic [FieldW-1:0] minute_value;
  logic [FieldW-1:0] second_value;

  // calculation stages
  logic              fields_ok;
  logic [YoeW-1:0]   yoe;
  logic [DoyW-1:0]   doy;
  logic [HmsW-1:0]   hms;
  logic [DaysW-1:0]  days;
  logic [SecsW-1:0]  secs;

  logic              in_fire;
  logic              is_digit;
  logic [3:0]        dig;
  logic [YearW-1:0]  year_acc;
  logic [FieldW-1:0] field_acc_m;
  logic [FieldW-1:0] field_acc_d;
  logic [FieldW-1:0] field_acc_h;
  logic [FieldW-1:0] field_acc_mi;
  logic [FieldW-1:0] field_acc_s;

  logic              fields_ok_next;
  logic              early_month;
  logic [MpW-1:0]    mp;
  logic [YoeW-1:0]   yoe_next;
  logic [DoyW-1:0]   doy_next;
  logic [HmsW-1:0]   hms_next;
  logic [DaysW-1:0]  days_next;
  logic [SecsW-1:0]  secs_next;
  logic              result_ok;

  assign in_fire         = cmd.take && in_valid;
  assign stat.last_taken = in_fire && in_last;
  assign stat.out_free   = !out_valid || out_ready;

  // character decode and digit accumulation
  assign is_digit     = (in_ch >= CharZero) && (in_ch <= CharNine);
  assign dig          = in_ch[3:0];
  assign year_acc     = year_value * YearW'(10) + YearW'(dig);
  assign field_acc_m  = month_value * FieldW'(10) + FieldW'(dig);
  assign field_acc_d  = day_value * FieldW'(10) + FieldW'(dig);
  assign field_acc_h  = hour_value * FieldW'(10) + FieldW'(dig);
  assign field_acc_mi = minute_value * FieldW'(10) + FieldW'(dig);
  assign field_acc_s  = second_value * FieldW'(10) + FieldW'(dig);

  always_ff @(posedge clk) begin
    if (rst || cmd.stage1) begin
      char_position <= '0;
      format_error  <= 1'b0;
      year_value    <= '0;
      month_value   <= '0;
      day_value     <= '0;
      hour_value    <= '0;
      minute_value  <= '0;
      second_value  <= '0;
    end else if (in_fire) begin
      if (char_position >= PosLen) begin
        format_error <= 1'b1;
      end else if (char_position == PosSep) begin
        if (in_ch != CharSep) format_error <= 1'b1;
      end else if (!is_digit) begin
        format_error <= 1'b1;
      end else if (char_position < PosMonth) begin
        year_value <= year_acc;
      end else if (char_position < PosDay) begin
        month_value <= field_acc_m;
      end else if (char_position < PosSep) begin
        day_value <= field_acc_d;
      end else if (char_position < PosMinute) begin
        hour_value <= field_acc_h;
      end else if (char_position < PosSecond) begin
        minute_value <= field_acc_mi;
      end else begin
        second_value <= field_acc_s;
      end
      char_position <= (char_position >= PosSat) ? PosSat : char_position + PosW'(1);
    end
  end

  // stage 1: range checks, year of era, day of year, time of day
  assign fields_ok_next = !format_error && (char_position == PosLen) &&
                          (year_value >= YearMin) && (year_value <= YearMax) &&
                          (month_value >= FieldW'(1)) && (month_value <= MonthMax) &&
                          (day_value >= FieldW'(1)) && (day_value <= DayMax) &&
                          (hour_value <= HourMax) && (minute_value <= MinSecMax) &&
                          (second_value <= MinSecMax);
  assign early_month = (month_value <= FieldW'(2));
  assign mp          = early_month ? MpW'(month_value + FieldW'(9))
                                   : MpW'(month_value - FieldW'(3));
  assign yoe_next    = YoeW'(year_value - EraYear - YearW'(early_month));
  assign doy_next    = month_start(mp) + DoyW'(day_value) - DoyW'(1);
  assign hms_next    = HmsW'(hour_value) * SecsPerHour + HmsW'(minute_value) * SecsPerMin +
                       HmsW'(second_value);

  // stage 2: days since epoch
  assign days_next = DaysBase + DaysW'(yoe) * DaysPerYear +
                     DaysW'(yoe[YoeW-1:2]) + DaysW'(doy);

  // stage 3: seconds since epoch
  assign secs_next = SecsW'(days) * SecsPerDay + SecsW'(hms);

  assign result_ok = fields_ok && (secs >= EpochMin) && !secs[SecsW-1];

  always_ff @(posedge clk) begin
    if (cmd.stage1) begin
      fields_ok <= fields_ok_next;
      yoe       <= yoe_next;
      doy       <= doy_next;
      hms       <= hms_next;
    end
    if (cmd.stage2) begin
      days <= days_next;
    end
    if (cmd.stage3) begin
      secs <= secs_next;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      out_valid_res <= result_ok;
      out_epoch     <= result_ok ? secs[EpochW-1:0] : '0;
    end
  end

  // checks
  a_gather_cleared: assert property (@(posedge clk) disable iff (rst)
    cmd.stage1 |=> (char_position == '0) && !format_error)
    else $error("gathered state not cleared after capture");

  a_pos_saturates: assert property (@(posedge clk) disable iff (rst)
    char_position <= PosSat)
    else $error("character position beyond saturation");

  a_valid_epoch_min: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_valid_res) |-> (out_epoch >= EpochMin[EpochW-1:0]))
    else $error("valid result below minimum epoch");

  a_invalid_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_valid_res) |-> (out_epoch == '0))
    else $error("invalid result with nonzero epoch");

  a_load_shows: assert property (@(posedge clk) disable iff (rst)
    cmd.load |=> out_valid)
    else $error("loaded result not presented");

endmodule

`default_nettype wire
